/* src/rcp_pkg.sv */
package rcp_pkg;

  // Channel count and capture timer rate
  localparam int CHANNELS     = 6;
  localparam int CAP_TICKS_US = 80;

  // Fixed field widths
  localparam int CHAN_W  = 3;
  localparam int US_W    = 16;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [US_W-1:0] VALID_MIN_RST = 16'd800;
  localparam logic [US_W-1:0] VALID_MAX_RST = 16'd2200;
  localparam logic [US_W-1:0] TIMEOUT_RST   = 16'd100;
  localparam logic [US_W-1:0] CENTER_RST    = 16'd1500;

  // Reciprocal for the tick-to-microsecond divide: floor(2^32 / CAP_TICKS_US)
  localparam logic [TIME_W:0]   RECIP   = 33'((64'd1 << 32) / CAP_TICKS_US);
  localparam logic [TIME_W-1:0] TICKS_L = 32'(CAP_TICKS_US);

  // Max tree over channels
  localparam int TREE_LVLS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LEAVES    = 1 << TREE_LVLS;

  typedef enum logic {
    CMD_EDGE  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VALID_MIN = 2'd0,
    CFG_VALID_MAX = 2'd1,
    CFG_TIMEOUT   = 2'd2,
    CFG_CENTER    = 2'd3
  } cfg_idx_e;

  // Status summary across all channels
  typedef struct packed {
    logic              any_signal;
    logic [TIME_W-1:0] newest_age;
  } status_t;

endpackage

/* src/rc_pulse_capture_timeout_top.sv */
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_we_i               cfg_idx_i, cfg_wdata_i
// in       in         in_valid_i/in_stall_o  cmd, chan, edge_rising, cap_ticks, now_ms
// out      out        out_valid_o/out_stall_i width, flags, times, pulse_accepted
//
// One item per cycle while out_stall_i is low; items pass the s1, s2 and output registers.
// Stage 1 keeps rise stamps and forms the reciprocal product, stage 2 corrects the quotient,
// range-checks, updates held widths and answers queries, then the output register.
// Stages move on their own; input is taken during an output stall while a stage is empty.
// Reset restores the register defaults and every channel's held width to 1500 us.
module rc_pulse_capture_timeout_top import rcp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // input beats
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [CHAN_W-1:0]    chan_i,
  input  logic                 edge_rising_i,
  input  logic [TIME_W-1:0]    cap_ticks_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  // result beats
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [US_W-1:0]      width_us_o,
  output logic                 width_valid_o,
  output logic                 chan_fresh_o,
  output logic [TIME_W-1:0]    last_update_ms_o,
  output logic                 any_signal_o,
  output logic [TIME_W-1:0]    newest_age_ms_o,
  output logic                 pulse_accepted_o
);

  // Configuration registers
  logic [US_W-1:0] valid_min_q, valid_max_q, timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_min_q <= VALID_MIN_RST;
      valid_max_q <= VALID_MAX_RST;
      timeout_q   <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_VALID_MIN: valid_min_q <= cfg_wdata_i;
        CFG_VALID_MAX: valid_max_q <= cfg_wdata_i;
        CFG_TIMEOUT:   timeout_q   <= cfg_wdata_i;
        // center only sets the held width at reset, which is fixed
        CFG_CENTER:    ;
        default:       ;
      endcase
    end
  end

  // Stage handshake
  logic ready_out, ready_s2, ready_s1;
  logic s1_v_q, s2_v_q, out_v_q;
  logic fire_s1, fire_s2;

  assign ready_out  = !out_v_q || !out_stall_i;
  assign ready_s2   = !s2_v_q || ready_out;
  assign ready_s1   = !s1_v_q || ready_s2;
  assign in_stall_o = !ready_s1;
  assign fire_s1    = s1_v_q && ready_s2;
  assign fire_s2    = s2_v_q && ready_out;

  // Input register
  logic              s1_cmd_q, s1_rise_q;
  logic [CHAN_W-1:0] s1_chan_q;
  logic [TIME_W-1:0] s1_ticks_q, s1_now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (ready_s1) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_s1 && in_valid_i) begin
      s1_cmd_q   <= cmd_i;
      s1_chan_q  <= chan_i;
      s1_rise_q  <= edge_rising_i;
      s1_ticks_q <= cap_ticks_i;
      s1_now_q   <= now_ms_i;
    end
  end

  // Stage 1: rise stamps and reciprocal product
  logic [TIME_W-1:0]   rise_stamp_q [CHANNELS];
  logic [CHANNELS-1:0] rise_seen_q;
  logic                s1_chan_ok, s1_edge, s1_seen, s1_fall_ok;
  logic [TIME_W-1:0]   s1_stamp, s1_dt;
  logic [2*TIME_W:0]   s1_prod;

  always_comb begin
    s1_stamp = '0;
    s1_seen  = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(s1_chan_q) == i) begin
        s1_stamp = rise_stamp_q[i];
        s1_seen  = rise_seen_q[i];
      end
    end
  end

  assign s1_chan_ok = int'(s1_chan_q) < CHANNELS;
  assign s1_edge    = (cmd_e'(s1_cmd_q) == CMD_EDGE) && s1_chan_ok;
  assign s1_fall_ok = s1_edge && !s1_rise_q && s1_seen;
  assign s1_dt      = s1_ticks_q - s1_stamp;
  assign s1_prod    = 65'(s1_dt) * 65'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_seen_q <= '0;
    end else if (fire_s1 && s1_edge) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (int'(s1_chan_q) == i) begin
          if (s1_rise_q) begin
            rise_seen_q[i] <= 1'b1;
          end else begin
            rise_seen_q[i] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_stamp_q <= '{default: '0};
    end else if (fire_s1 && s1_edge && s1_rise_q) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (int'(s1_chan_q) == i) begin
          rise_stamp_q[i] <= s1_ticks_q;
        end
      end
    end
  end

  // Stage 2 register
  logic              s2_cmd_q, s2_fall_ok_q;
  logic [CHAN_W-1:0] s2_chan_q;
  logic [TIME_W-1:0] s2_now_q, s2_dt_q, s2_q0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (ready_s2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_s1) begin
      s2_cmd_q     <= s1_cmd_q;
      s2_chan_q    <= s1_chan_q;
      s2_now_q     <= s1_now_q;
      s2_fall_ok_q <= s1_fall_ok;
      s2_dt_q      <= s1_dt;
      s2_q0_q      <= s1_prod[2*TIME_W-1:TIME_W];
    end
  end

  // Stage 2: quotient correction and range check
  logic [TIME_W-1:0] s2_rem, s2_quot;
  logic [US_W-1:0]   s2_width;
  logic              s2_accept;

  assign s2_rem    = s2_dt_q - (s2_q0_q * TICKS_L);
  assign s2_quot   = s2_q0_q + 32'(s2_rem >= TICKS_L);
  assign s2_width  = s2_quot[US_W-1:0];
  assign s2_accept = s2_fall_ok_q && (s2_width >= valid_min_q) && (s2_width <= valid_max_q);

  // Held channel state
  logic [US_W-1:0]     held_width_q [CHANNELS];
  logic [CHANNELS-1:0] held_valid_q;
  logic [TIME_W-1:0]   update_time_q [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_width_q  <= '{default: CENTER_RST};
      held_valid_q  <= '0;
      update_time_q <= '{default: '0};
    end else if (fire_s2 && s2_accept) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (int'(s2_chan_q) == i) begin
          held_width_q[i]  <= s2_width;
          held_valid_q[i]  <= 1'b1;
          update_time_q[i] <= s2_now_q;
        end
      end
    end
  end

  // Query read of the selected channel
  logic [US_W-1:0]   q_width;
  logic              q_valid, q_chan_ok, s2_query;
  logic [TIME_W-1:0] q_update, q_age;
  status_t           status;

  always_comb begin
    q_width  = '0;
    q_valid  = 1'b0;
    q_update = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(s2_chan_q) == i) begin
        q_width  = held_width_q[i];
        q_valid  = held_valid_q[i];
        q_update = update_time_q[i];
      end
    end
  end

  assign q_chan_ok = int'(s2_chan_q) < CHANNELS;
  assign s2_query  = cmd_e'(s2_cmd_q) == CMD_QUERY;
  assign q_age     = s2_now_q - q_update;

  rcp_status u_status (
    .now_i         (s2_now_q),
    .timeout_i     (timeout_q),
    .update_time_i (update_time_q),
    .held_valid_i  (held_valid_q),
    .status_o      (status)
  );

  // Result register
  logic [US_W-1:0]   width_d, width_q;
  logic              wvalid_d, wvalid_q, fresh_d, fresh_q, any_d, any_q, pacc_d, pacc_q;
  logic [TIME_W-1:0] last_d, last_q, age_d, age_q;
  logic              q_sel;

  assign q_sel    = s2_query && q_chan_ok;
  assign width_d  = q_sel ? q_width : '0;
  assign wvalid_d = q_sel && q_valid && (q_age <= {16'd0, timeout_q});
  assign fresh_d  = q_sel && q_valid && (q_age < {16'd0, timeout_q});
  assign last_d   = q_sel ? q_update : '0;
  assign any_d    = s2_query && status.any_signal;
  assign age_d    = s2_query ? status.newest_age : '0;
  assign pacc_d   = s2_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ready_out) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_s2) begin
      width_q  <= width_d;
      wvalid_q <= wvalid_d;
      fresh_q  <= fresh_d;
      last_q   <= last_d;
      any_q    <= any_d;
      age_q    <= age_d;
      pacc_q   <= pacc_d;
    end
  end

  assign out_valid_o      = out_v_q;
  assign width_us_o       = width_q;
  assign width_valid_o    = wvalid_q;
  assign chan_fresh_o     = fresh_q;
  assign last_update_ms_o = last_q;
  assign any_signal_o     = any_q;
  assign newest_age_ms_o  = age_q;
  assign pulse_accepted_o = pacc_q;

  // Checks
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  a_fresh_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chan_fresh_o |-> width_valid_o)
    else $error("fresh flag without width valid");

  a_accept_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_s2 && s2_accept |=> out_valid_o && pulse_accepted_o)
    else $error("accepted pulse lost on the way out");

  a_edge_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pulse_accepted_o |-> !any_signal_o && !width_valid_o &&
    (newest_age_ms_o == '0))
    else $error("edge beat carries query fields");

endmodule

/* src/rcp_status.sv */
module rcp_status import rcp_pkg::*; (
  input  logic [TIME_W-1:0] now_i,
  input  logic [US_W-1:0]   timeout_i,
  input  logic [TIME_W-1:0] update_time_i [CHANNELS],
  input  logic [CHANNELS-1:0] held_valid_i,
  output status_t           status_o
);

  logic [CHANNELS-1:0] fresh;
  logic [TIME_W-1:0]   node [TREE_LVLS+1][LEAVES];
  logic [TIME_W-1:0]   newest;

  // Per-channel freshness, all in parallel
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      fresh[i] = held_valid_i[i] &&
                 ((now_i - update_time_i[i]) < {16'd0, timeout_i});
    end
  end

  // Balanced max tree over update times, unused leaves read as zero
  always_comb begin
    node = '{default: '0};
    for (int n = 0; n < CHANNELS; n++) begin
      node[0][n] = update_time_i[n];
    end
    for (int l = 0; l < TREE_LVLS; l++) begin
      for (int n = 0; n < (LEAVES >> (l + 1)); n++) begin
        node[l+1][n] = (node[l][2*n] > node[l][2*n+1]) ? node[l][2*n] : node[l][2*n+1];
      end
    end
    newest = node[TREE_LVLS][0];
  end

  // Zero as the newest time means no update at all
  assign status_o.any_signal = |fresh;
  assign status_o.newest_age = (newest == '0) ? '1 : (now_i - newest);

endmodule
